FILE: rtl/voxel_face_visibility_top_assert.svh
// Assertion macros shared by the voxel face visibility RTL
`ifndef VOXEL_FACE_VISIBILITY_TOP_ASSERT_SVH
`define VOXEL_FACE_VISIBILITY_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define VFV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define VFV_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/vfv_pkg.sv
// Shared types, constants and helpers of the voxel face visibility block
package vfv_pkg;

  localparam int unsigned GRID_WIDTH  = 16;
  localparam int unsigned GRID_HEIGHT = 16;
  localparam int unsigned GRID_DEPTH  = 16;

  localparam int unsigned COORD_W   = 4;
  localparam int unsigned KIND_W    = 8;
  localparam int unsigned ROW_COUNT = GRID_WIDTH * GRID_HEIGHT;
  localparam int unsigned ROW_AW    = $clog2(ROW_COUNT);

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // row reads of one query, in issue order
  localparam int unsigned STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_OWN = 3'd0;
  localparam logic [STEP_W-1:0] STEP_XM  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_XP  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_YM  = 3'd3;
  localparam logic [STEP_W-1:0] STEP_YP  = 3'd4;
  localparam int unsigned       STEPS_N  = 5;

  // face bit positions
  localparam int unsigned FACE_XM = 0;
  localparam int unsigned FACE_XP = 1;
  localparam int unsigned FACE_YM = 2;
  localparam int unsigned FACE_YP = 3;
  localparam int unsigned FACE_ZM = 4;
  localparam int unsigned FACE_ZP = 5;
  localparam int unsigned FACES   = 6;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [COORD_W:0]   ncoord_t;   // room for a +1 neighbor
  typedef logic [GRID_DEPTH-1:0] row_t;

  typedef struct packed {
    logic                mode;
    coord_t              pos_x;
    coord_t              pos_y;
    coord_t              pos_z;
    logic [KIND_W-1:0]   block_kind;
  } vfv_in_t;

  typedef struct packed {
    logic [FACES-1:0] face_mask;
    logic             any_visible;
  } vfv_out_t;

  typedef struct packed {
    logic              en;
    logic              we;
    logic [ROW_AW-1:0] addr;
    row_t              wdata;
  } mem_req_t;

  function automatic logic [ROW_AW-1:0] row_addr(ncoord_t x, ncoord_t y);
    return ROW_AW'(x * GRID_HEIGHT + y);
  endfunction

  function automatic logic in_grid(coord_t x, coord_t y, coord_t z);
    return (x < GRID_WIDTH) && (y < GRID_HEIGHT) && (z < GRID_DEPTH);
  endfunction

  // solid bit z of a row; shifting past the top reads as air
  function automatic logic row_bit(row_t row, ncoord_t z);
    row_t sh;
    sh = row >> z;
    return sh[0];
  endfunction

endpackage

FILE: rtl/vfv_ram.sv
// Generic single-port RAM with registered read data
module vfv_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end else begin
        rdata_r <= mem_r[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/vfv_seq.sv
// Request sequencer: row read-modify-write for loads, up to five row reads per query
module vfv_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  output logic              req_stall,
  input  vfv_pkg::vfv_in_t  req,
  output logic              res_valid,
  input  logic              res_ready,
  output vfv_pkg::vfv_out_t res,
  output vfv_pkg::mem_req_t mem_req,
  input  vfv_pkg::row_t     mem_rdata
);

  `include "voxel_face_visibility_top_assert.svh"

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_LOAD_RD = 3'd1;
  localparam logic [2:0] S_LOAD_WR = 3'd2;
  localparam logic [2:0] S_QRD     = 3'd3;
  localparam logic [2:0] S_QLAST   = 3'd4;
  localparam logic [2:0] S_DONE    = 3'd5;

  logic [2:0]                   state_r, state_nxt;
  logic [vfv_pkg::STEP_W-1:0]   cnt_r, cnt_nxt;
  logic [vfv_pkg::FACES-1:0]    nb_r, nb_nxt;
  logic                         own_r, own_nxt;
  vfv_pkg::vfv_in_t             item_r;

  logic                         accept;
  logic                         grid_ok;
  logic [vfv_pkg::STEPS_N-1:0]  step_ok;
  vfv_pkg::ncoord_t             ix, iy, iz;
  vfv_pkg::ncoord_t             sx, sy;
  logic                         cap_en;
  logic [vfv_pkg::STEP_W-1:0]   cap_step;
  logic                         cap_bit;
  vfv_pkg::row_t                one_hot;

  assign accept  = req_valid && !req_stall;
  assign grid_ok = vfv_pkg::in_grid(item_r.pos_x, item_r.pos_y, item_r.pos_z);
  assign ix = {1'b0, item_r.pos_x};
  assign iy = {1'b0, item_r.pos_y};
  assign iz = {1'b0, item_r.pos_z};

  // which neighbor rows exist inside the grid
  always_comb begin
    step_ok[vfv_pkg::STEP_OWN] = grid_ok;
    step_ok[vfv_pkg::STEP_XM]  = grid_ok && (ix != '0);
    step_ok[vfv_pkg::STEP_XP]  = grid_ok && ((ix + 1'b1) < vfv_pkg::GRID_WIDTH);
    step_ok[vfv_pkg::STEP_YM]  = grid_ok && (iy != '0);
    step_ok[vfv_pkg::STEP_YP]  = grid_ok && ((iy + 1'b1) < vfv_pkg::GRID_HEIGHT);
  end

  // row coordinates of the read issued this cycle
  always_comb begin
    sx = ix;
    sy = iy;
    unique case (cnt_r)
      vfv_pkg::STEP_OWN: ;
      vfv_pkg::STEP_XM:  sx = ix - 1'b1;
      vfv_pkg::STEP_XP:  sx = ix + 1'b1;
      vfv_pkg::STEP_YM:  sy = iy - 1'b1;
      vfv_pkg::STEP_YP:  sy = iy + 1'b1;
      default: ;
    endcase
  end

  assign one_hot = vfv_pkg::row_t'(1) << iz;

  always_comb begin
    mem_req       = '0;
    mem_req.addr  = vfv_pkg::row_addr(sx, sy);
    mem_req.wdata = (item_r.block_kind != '0) ? (mem_rdata | one_hot)
                                              : (mem_rdata & ~one_hot);
    unique case (state_r)
      S_LOAD_RD: mem_req.en = 1'b1;
      S_LOAD_WR: begin
        mem_req.en = 1'b1;
        mem_req.we = 1'b1;
      end
      S_QRD:     mem_req.en = step_ok[cnt_r];
      default: ;
    endcase
  end

  // read data of the previous step's row
  assign cap_en   = (state_r == S_QRD && cnt_r != '0) || (state_r == S_QLAST);
  assign cap_step = (state_r == S_QLAST) ? vfv_pkg::STEP_YP : cnt_r - 1'b1;
  assign cap_bit  = step_ok[cap_step] && vfv_pkg::row_bit(mem_rdata, iz);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    nb_nxt    = nb_r;
    own_nxt   = own_r;
    if (cap_en) begin
      unique case (cap_step)
        vfv_pkg::STEP_OWN: begin
          own_nxt = cap_bit;
          nb_nxt[vfv_pkg::FACE_ZM] = step_ok[vfv_pkg::STEP_OWN] && (iz != '0) &&
                                     vfv_pkg::row_bit(mem_rdata, iz - 1'b1);
          nb_nxt[vfv_pkg::FACE_ZP] = step_ok[vfv_pkg::STEP_OWN] &&
                                     vfv_pkg::row_bit(mem_rdata, iz + 1'b1);
        end
        vfv_pkg::STEP_XM: nb_nxt[vfv_pkg::FACE_XM] = cap_bit;
        vfv_pkg::STEP_XP: nb_nxt[vfv_pkg::FACE_XP] = cap_bit;
        vfv_pkg::STEP_YM: nb_nxt[vfv_pkg::FACE_YM] = cap_bit;
        vfv_pkg::STEP_YP: nb_nxt[vfv_pkg::FACE_YP] = cap_bit;
        default: ;
      endcase
    end
    unique case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (accept) begin
          if (req.mode == vfv_pkg::MODE_QUERY) begin
            state_nxt = S_QRD;
          end else if (vfv_pkg::in_grid(req.pos_x, req.pos_y, req.pos_z)) begin
            state_nxt = S_LOAD_RD;
          end
        end
      end
      S_LOAD_RD: state_nxt = S_LOAD_WR;
      S_LOAD_WR: state_nxt = S_IDLE;
      S_QRD: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == vfv_pkg::STEP_YP) begin
          state_nxt = S_QLAST;
        end
      end
      S_QLAST:   state_nxt = S_DONE;
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nb_r  <= nb_nxt;
    own_r <= own_nxt;
    if (accept) begin
      item_r <= req;
    end
  end

  assign req_stall       = (state_r != S_IDLE);
  assign res_valid       = (state_r == S_DONE);
  assign res.face_mask   = own_r ? ~nb_r : '0;
  assign res.any_visible = own_r && (nb_r != '1);

  `VFV_ASSERT_IMP(a_write_only_in_wr, mem_req.we, state_r == S_LOAD_WR, "write outside load")
  `VFV_ASSERT_NXT(a_read_then_write, state_r == S_LOAD_RD, mem_req.we && mem_req.en,
                  "load read not followed by write")
  `VFV_ASSERT_NXT(a_take_to_idle, res_valid && res_ready, state_r == S_IDLE,
                  "result taken but sequencer busy")
  `VFV_ASSERT_IMP(a_air_no_faces, res_valid && !own_r, res.face_mask == '0,
                  "air voxel reports faces")

endmodule

FILE: rtl/voxel_face_visibility_top.sv
// Voxel face visibility: solid/air grid with per-voxel face culling queries
//
//   port group  dir  payload    meaning
//   in_*        in   vfv_in_t   load a voxel or query one
//   out_*       out  vfv_out_t  face mask and any-visible flag, one per query
//
// A load steps through accept, row read and row write back; a query steps through
// accept, five row-read steps on the single-port grid RAM, last capture and result.
// One request is in flight at a time; the next is accepted once the result sits
// in the output register, so a stalled output holds that register and the next result.
// Reset (rst_n low, synchronous) clears control; grid rows are undefined until
// loaded. Out-of-grid loads are dropped; out-of-grid queries answer zero.
module voxel_face_visibility_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  vfv_pkg::vfv_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output vfv_pkg::vfv_out_t out_data
);

  `include "voxel_face_visibility_top_assert.svh"

  logic              res_valid;
  logic              res_ready;
  logic              res_take;
  vfv_pkg::vfv_out_t res;
  vfv_pkg::mem_req_t mem_req;
  vfv_pkg::row_t     mem_rdata;

  logic              out_valid_r, out_valid_nxt;
  vfv_pkg::vfv_out_t out_data_r;

  vfv_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_valid),
    .req_stall (in_stall),
    .req       (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  vfv_ram #(
    .WIDTH (vfv_pkg::GRID_DEPTH),
    .DEPTH (vfv_pkg::ROW_COUNT)
  ) u_grid (
    .clk   (clk),
    .en    (mem_req.en),
    .we    (mem_req.we),
    .addr  (mem_req.addr),
    .wdata (mem_req.wdata),
    .rdata (mem_rdata)
  );

  assign res_ready = !out_valid_r || !out_stall;
  assign res_take  = res_valid && res_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `VFV_ASSERT_IMP(a_no_overwrite, out_valid_r && out_stall, !res_take,
                  "held result overwritten")
  `VFV_ASSERT_NXT(a_take_shows, res_take, out_valid_r, "taken result not presented")

endmodule

FILE: verif/vfv_face_checker.sv
// Face visibility checker: mirrors the solid/air grid and compares each query answer
module vfv_face_checker
  import vfv_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  vfv_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  vfv_out_t out_data,
  output int       mismatch_count,
  output int       pending_faces
);

  row_t     solid_bits [ROW_COUNT];
  vfv_out_t expected_faces [$];
  vfv_out_t oldest;
  int       errs = 0;

  assign mismatch_count = errs;
  assign pending_faces  = expected_faces.size();

  initial begin
    foreach (solid_bits[i]) solid_bits[i] = '0;
  end

  // outside the grid reads as air
  function automatic logic is_solid(int x, int y, int z);
    if (x < 0 || x >= int'(GRID_WIDTH) || y < 0 || y >= int'(GRID_HEIGHT) ||
        z < 0 || z >= int'(GRID_DEPTH))
      return 1'b0;
    return solid_bits[x * int'(GRID_HEIGHT) + y][z];
  endfunction

  function automatic vfv_out_t visible_faces(int x, int y, int z);
    vfv_out_t r;
    r = '0;
    if (is_solid(x, y, z)) begin
      r.face_mask[FACE_XM] = !is_solid(x - 1, y, z);
      r.face_mask[FACE_XP] = !is_solid(x + 1, y, z);
      r.face_mask[FACE_YM] = !is_solid(x, y - 1, z);
      r.face_mask[FACE_YP] = !is_solid(x, y + 1, z);
      r.face_mask[FACE_ZM] = !is_solid(x, y, z - 1);
      r.face_mask[FACE_ZP] = !is_solid(x, y, z + 1);
    end
    r.any_visible = |r.face_mask;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        if (in_data.mode == MODE_LOAD) begin
          if (in_grid(in_data.pos_x, in_data.pos_y, in_data.pos_z))
            solid_bits[int'(in_data.pos_x) * int'(GRID_HEIGHT) + int'(in_data.pos_y)]
              [in_data.pos_z] = (in_data.block_kind != '0);
        end else begin
          expected_faces.push_back(visible_faces(int'(in_data.pos_x),
                                                 int'(in_data.pos_y),
                                                 int'(in_data.pos_z)));
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_faces.size() == 0) begin
          $display("%0t: face result with no query pending: mask %b any %b",
                   $time, out_data.face_mask, out_data.any_visible);
          errs++;
        end else begin
          oldest = expected_faces.pop_front();
          if (out_data.face_mask !== oldest.face_mask) begin
            $display("%0t: face_mask expected %b got %b",
                     $time, oldest.face_mask, out_data.face_mask);
            errs++;
          end
          if (out_data.any_visible !== oldest.any_visible) begin
            $display("%0t: any_visible expected %b got %b",
                     $time, oldest.any_visible, out_data.any_visible);
            errs++;
          end
        end
      end
    end
  end

endmodule

FILE: verif/tb.sv
// Testbench top: load/query stimulus, handshake pressure and verdict for face culling
module tb;
  import vfv_pkg::*;

  localparam int NUM_REQS     = 1650;
  localparam int QUIET_AFTER  = 1500;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 24;
  localparam int XMAX = int'(GRID_WIDTH) - 1;
  localparam int YMAX = int'(GRID_HEIGHT) - 1;
  localparam int ZMAX = int'(GRID_DEPTH) - 1;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  vfv_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  vfv_out_t out_data;

  int mismatch_count;
  int pending_faces;
  int reqs_sent = 0;
  int results_taken = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int burst_len;
  bit quiet = 1'b0;
  bit long_hold_done = 1'b0;
  bit loaded [ROW_COUNT * GRID_DEPTH];

  voxel_face_visibility_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  vfv_face_checker u_face_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .mismatch_count (mismatch_count),
    .pending_faces  (pending_faces)
  );

  initial forever #5 clk = ~clk;

  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) results_taken <= results_taken + 1;
  end

  function automatic int vox_idx(int x, int y, int z);
    return (x * int'(GRID_HEIGHT) + y) * int'(GRID_DEPTH) + z;
  endfunction

  function automatic int clamp_coord(int v, int hi);
    return (v < 0) ? 0 : ((v > hi) ? hi : v);
  endfunction

  // bias toward the grid faces so edge neighbors come up often
  function automatic int pick_coord(int hi);
    if ($urandom_range(0, 9) < 3) return ($urandom_range(0, 1) != 0) ? hi : 0;
    return int'($urandom_range(0, hi));
  endfunction

  function automatic logic [KIND_W-1:0] random_kind();
    if ($urandom_range(0, 99) < 45) return '0;
    return KIND_W'($urandom_range(1, 255));
  endfunction

  task automatic send_req(vfv_in_t req);
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    reqs_sent++;
  endtask

  task automatic load_voxel(int x, int y, int z, logic [KIND_W-1:0] kind);
    vfv_in_t req;
    req.mode       = MODE_LOAD;
    req.pos_x      = coord_t'(x);
    req.pos_y      = coord_t'(y);
    req.pos_z      = coord_t'(z);
    req.block_kind = kind;
    send_req(req);
    loaded[vox_idx(x, y, z)] = 1'b1;
  endtask

  // a query may only touch voxels written since reset
  task automatic fill_voxel(int x, int y, int z);
    if (x >= 0 && x <= XMAX && y >= 0 && y <= YMAX && z >= 0 && z <= ZMAX)
      if (!loaded[vox_idx(x, y, z)]) load_voxel(x, y, z, random_kind());
  endtask

  task automatic query_voxel(int x, int y, int z);
    vfv_in_t req;
    fill_voxel(x, y, z);
    fill_voxel(x - 1, y, z);
    fill_voxel(x + 1, y, z);
    fill_voxel(x, y - 1, z);
    fill_voxel(x, y + 1, z);
    fill_voxel(x, y, z - 1);
    fill_voxel(x, y, z + 1);
    req.mode       = MODE_QUERY;
    req.pos_x      = coord_t'(x);
    req.pos_y      = coord_t'(y);
    req.pos_z      = coord_t'(z);
    req.block_kind = KIND_W'($urandom_range(0, 255));
    send_req(req);
  endtask

  // result side: random stall bursts, one long hold-off to back up the input
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!long_hold_done && !quiet && results_taken >= 150) begin
        long_hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
        burst_len = $urandom_range(1, 8);
        out_stall <= 1'b1;
        repeat (burst_len) @(posedge clk);
        out_stall <= 1'b0;
      end
      if ($urandom_range(0, 31) == 0)
        rx_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(10, 50));
    end
  end

  initial begin
    int cx, cy, cz;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // low corner: grid edge on three sides, kind 255 and kind 1 count as solid
    load_voxel(0, 0, 0, 8'hFF);
    load_voxel(1, 0, 0, 8'h00);
    load_voxel(0, 1, 0, 8'h00);
    load_voxel(0, 0, 1, 8'h01);
    query_voxel(0, 0, 0);

    // high corner
    load_voxel(XMAX, YMAX, ZMAX, 8'h80);
    load_voxel(XMAX - 1, YMAX, ZMAX, 8'h7F);
    load_voxel(XMAX, YMAX - 1, ZMAX, 8'h00);
    load_voxel(XMAX, YMAX, ZMAX - 1, 8'h00);
    query_voxel(XMAX, YMAX, ZMAX);

    // fully enclosed voxel shows nothing, then turned to air
    load_voxel(7, 8, 9, 8'h55);
    load_voxel(6, 8, 9, 8'hAA);
    load_voxel(8, 8, 9, 8'h01);
    load_voxel(7, 7, 9, 8'hFF);
    load_voxel(7, 9, 9, 8'h02);
    load_voxel(7, 8, 8, 8'h40);
    load_voxel(7, 8, 10, 8'h10);
    query_voxel(7, 8, 9);
    load_voxel(7, 8, 9, 8'h00);
    query_voxel(7, 8, 9);

    while (reqs_sent < NUM_REQS) begin
      if (reqs_sent >= QUIET_AFTER) begin
        if (!quiet) quiet <= 1'b1;
        tx_idle_pct = 0;
      end else begin
        tx_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(5, 40));
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          // local cluster: reshape a neighborhood, then query around it
          cx = pick_coord(XMAX);
          cy = pick_coord(YMAX);
          cz = pick_coord(ZMAX);
          repeat ($urandom_range(0, 6))
            load_voxel(clamp_coord(cx + int'($urandom_range(0, 2)) - 1, XMAX),
                       clamp_coord(cy + int'($urandom_range(0, 2)) - 1, YMAX),
                       clamp_coord(cz + int'($urandom_range(0, 2)) - 1, ZMAX),
                       random_kind());
          repeat ($urandom_range(2, 8))
            query_voxel(clamp_coord(cx + int'($urandom_range(0, 2)) - 1, XMAX),
                        clamp_coord(cy + int'($urandom_range(0, 2)) - 1, YMAX),
                        clamp_coord(cz + int'($urandom_range(0, 2)) - 1, ZMAX));
        end
        6, 7: begin
          repeat ($urandom_range(1, 6))
            load_voxel($urandom_range(0, XMAX), $urandom_range(0, YMAX),
                       $urandom_range(0, ZMAX), random_kind());
        end
        default: begin
          query_voxel($urandom_range(0, XMAX), $urandom_range(0, YMAX),
                      $urandom_range(0, ZMAX));
        end
      endcase
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending_faces != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_faces == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
